>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define WAGP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define WAGP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/wagp_pkg.sv
// package with constants, types and width helpers of the gap packer
package wagp_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 32;
    localparam int WORD_BITS            = 32;
    localparam int PAYLOAD_BITS         = 28;
    localparam int CODE_BITS            = 4;
    localparam int SCAN_TARGET          = 32;

    localparam logic [4:0] WIDTH_WIDE = 5'd28;
    localparam logic [3:0] CODE_WIDE  = 4'd0;

    typedef struct packed {
        logic [WORD_BITS-1:0] gap;
        logic                 list_end;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic                 ovf;
    } result_t;

    function automatic logic [5:0] bit_length(input logic [WORD_BITS-1:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (v[i])
            begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] round_width(input logic [5:0] bits);
        logic [4:0] w;
        if (bits > 6'd14)
        begin
            w = WIDTH_WIDE;
        end
        else if (bits > 6'd9)
        begin
            w = 5'd14;
        end
        else if (bits > 6'd7)
        begin
            w = 5'd9;
        end
        else if (bits > 6'd5)
        begin
            w = 5'd7;
        end
        else if (bits == 6'd0)
        begin
            w = 5'd1;
        end
        else
        begin
            w = bits[4:0];
        end
        return w;
    endfunction

    function automatic logic [4:0] gaps_per_word(input logic [4:0] w);
        logic [4:0] n;
        case (w)
            5'd1:    n = 5'd28;
            5'd2:    n = 5'd14;
            5'd3:    n = 5'd9;
            5'd4:    n = 5'd7;
            5'd5:    n = 5'd5;
            5'd7:    n = 5'd4;
            5'd9:    n = 5'd3;
            5'd14:   n = 5'd2;
            default: n = 5'd1;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/wagp_window_engine.sv
// gap window memory with the scan and pack sequencer
module wagp_window_engine #(
    parameter int WINDOW_DEPTH = wagp_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wagp_pkg::in_item_t in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output wagp_pkg::result_t  res
);
    import wagp_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int PW = 6 + CW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_SCAN  = 5'b00100,
        S_PACK  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 end_reg, end_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [5:0]           maxb_reg, maxb_next;
    logic [4:0]           width_reg, width_next;
    logic [CW-1:0]        take_reg, take_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [5:0]           pos_reg, pos_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 ovf_reg, ovf_next;

    logic [WORD_BITS-1:0] mem [WINDOW_DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;

    logic [5:0]           gap_bits;
    logic [5:0]           maxb_new;
    logic [CW-1:0]        k_inc;
    logic [PW-1:0]        prod;
    logic                 reached;
    logic                 scan_last;
    logic [4:0]           w_new;
    logic [CW-1:0]        n_new;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [CW-1:0]        idx_inc;

    function automatic logic [AW-1:0] wrap_idx(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(WINDOW_DEPTH))
        begin
            s = s - SW'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // scan and pack step on the entry in rdata_reg
    always_comb
    begin
        gap_bits  = bit_length(rdata_reg);
        if (gap_bits == 6'd0)
        begin
            gap_bits = 6'd1;
        end
        maxb_new  = (gap_bits > maxb_reg) ? gap_bits : maxb_reg;
        k_inc     = k_reg + CW'(1);
        prod      = PW'(maxb_new) * PW'(k_inc);
        reached   = prod >= PW'(SCAN_TARGET);
        scan_last = k_inc == count_reg;
        w_new     = round_width(maxb_new);
        n_new     = CW'(gaps_per_word(w_new));
        mask      = (32'h1 << width_reg) - 32'h1;
        masked    = rdata_reg & mask;
        idx_inc   = idx_reg + CW'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        end_next   = end_reg;
        k_next     = k_reg;
        maxb_next  = maxb_reg;
        width_next = width_reg;
        take_next  = take_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        ovf_next   = ovf_reg;
        rd_addr    = head_reg;
        wr_addr    = wrap_idx(head_reg, count_reg);
        wr_en      = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (count_reg < CW'(WINDOW_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    end_next   = in_item.list_end;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                k_next    = '0;
                maxb_next = 6'd0;
                if (count_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                maxb_next = maxb_new;
                if (reached || (scan_last && (end_reg || count_reg == CW'(WINDOW_DEPTH))))
                begin
                    width_next = w_new;
                    take_next  = (n_new < count_reg) ? n_new : count_reg;
                    idx_next   = '0;
                    pos_next   = 6'(CODE_BITS);
                    word_next  = {28'd0, (w_new == WIDTH_WIDE) ? CODE_WIDE : w_new[3:0]};
                    ovf_next   = 1'b0;
                    state_next = S_PACK;
                end
                else if (scan_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next  = k_inc;
                    rd_addr = wrap_idx(head_reg, k_inc);
                end
            end
            S_PACK:
            begin
                word_next = word_reg | (masked << pos_reg[4:0]);
                ovf_next  = ovf_reg | (|rdata_reg[WORD_BITS-1:PAYLOAD_BITS]);
                pos_next  = pos_reg + 6'(width_reg);
                idx_next  = idx_inc;
                rd_addr   = wrap_idx(head_reg, idx_inc);
                if (idx_inc == take_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    head_next  = wrap_idx(head_reg, take_reg);
                    count_next = count_reg - take_reg;
                    state_next = S_START;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.word = word_reg;
    assign res.last = end_reg && (count_reg == take_reg);
    assign res.ovf  = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            end_reg   <= 1'b0;
            k_reg     <= '0;
            maxb_reg  <= '0;
            width_reg <= 5'd1;
            take_reg  <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            end_reg   <= end_next;
            k_reg     <= k_next;
            maxb_reg  <= maxb_next;
            width_reg <= width_next;
            take_reg  <= take_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        ovf_reg  <= ovf_next;
    end

    // window memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_item.gap;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/word_aligned_gap_packer.sv
// top level of the word-aligned gap packer
// usage:
//   s_axis takes postings: tdata doc number, tuser list start, tlast list end.
//   m_axis gives packed words: tdata width code and gaps, tlast last word of
//   a list, tuser overflow (a gap wider than 28 bits was truncated).
//   one posting is taken at a time; s_axis_tready drops while the window is
//   scanned and the posting's words are formed.
// sequence:
//   a posting is accepted, then the window scan restarts; each word then
//   scans s gaps to pick the width (at most the window fill), packs t gaps
//   (at most 28) and is emitted. every posting rescans the window from its
//   oldest gap through the single read port. a posting that completes no
//   word returns to ready after the scan.
// reset:
//   clears the previous doc number, the window pointers and the output valid.
// stalls:
//   a finished word waits in the output register; the next word waits in the
//   engine until it is taken, and postings are taken again once the window
//   has no complete word left.
`include "assert_macros.svh"

module word_aligned_gap_packer #(
    parameter int WINDOW_DEPTH = wagp_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // doc_id
    input  logic        s_axis_tuser,  // list_start
    input  logic        s_axis_tlast,  // list_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // packed_word
    output logic        m_axis_tuser,  // overflow
    output logic        m_axis_tlast   // last_word
);
    import wagp_pkg::*;

    logic [WORD_BITS-1:0] prev_doc_reg;
    in_item_t             in_item;
    logic                 in_accept;
    logic                 res_valid;
    logic                 res_ready;
    result_t              res;
    logic                 load;
    logic                 m_valid_reg;
    result_t              m_res_reg;

    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign in_item.gap  = s_axis_tdata - (s_axis_tuser ? 32'd0 : prev_doc_reg);
    assign in_item.list_end = s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_doc_reg <= '0;
        end
        else if (in_accept)
        begin
            prev_doc_reg <= s_axis_tdata;
        end
    end

    wagp_window_engine #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_axis_tready;
    assign load      = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_res_reg.word;
    assign m_axis_tlast  = m_res_reg.last;
    assign m_axis_tuser  = m_res_reg.ovf;

    `WAGP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))
    `WAGP_ASSERT_NEXT(a_one_item, in_accept, !s_axis_tready)
    `WAGP_ASSERT_NEXT(a_out_drain, m_axis_tvalid && m_axis_tready && !load, !m_axis_tvalid)

endmodule
